[src/spq_pkg.sv]
// shared types and constants for the stable priority queue
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

    localparam int PRI_W = 16;
    localparam int TAG_W = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // broadcast command seen by every cell in the same cycle
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t ent;
    } cmd_t;

endpackage

[src/spq_cell.sv]
// one slot of the sorted chain: compares against the broadcast entry and
// shifts to or from its neighbors; depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
#(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic             aclk,
    input  cmd_t             cmd,
    input  logic [CNT_W-1:0] count,
    input  logic             take_left,
    input  entry_t           left_ent,
    input  entry_t           right_ent,
    output logic             take,
    output entry_t           ent
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    entry_t ent_reg;
    entry_t ent_next;
    logic   occupied;

    assign occupied = count > IDX;
    // new entry goes after everything of equal or higher priority
    assign take = cmd.enq && !(occupied && (ent_reg.pri >= cmd.ent.pri));
    assign ent = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (cmd.deq) begin
            ent_next = right_ent;
        end else if (take) begin
            ent_next = take_left ? left_ent : cmd.ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

[src/stable_priority_queue.sv]
// top level of the stable priority queue: chain of spq_cell slots, entry
// count and registered result; depends on spq_pkg and spq_cell
`timescale 1ns / 1ps

// Sorted priority queue of CAPACITY entries, highest priority at the head,
// equal priorities leaving in arrival order. Every slot compares its entry
// with an incoming request in parallel and the chain shifts by one place
// at once, so a request can be taken every cycle while the input is ready,
// and its result appears in the output register in the cycle after
// acceptance. The input is ready whenever the output register is empty or
// being read in the same cycle. There is no clearing pass after reset:
// slots above the entry count are never read.

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [PRI_W-1:0]    s_priority_req,
    input  logic [TAG_W-1:0]    s_task_tag,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [PRI_W-1:0]    m_out_priority,
    output logic [TAG_W-1:0]    m_out_tag,
    output logic [OCC_W-1:0]    m_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    entry_t              out_reg;
    entry_t              out_next;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic [CNT_W+OCC_W-1:0] count_ext;

    logic   accept;
    logic   full;
    logic   empty;
    cmd_t   cmd;
    entry_t cell_ent [CAPACITY];
    entry_t left_ent [CAPACITY];
    entry_t right_ent [CAPACITY];
    logic   take [CAPACITY];
    logic   take_left [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;
    assign full = count_reg == CAP;
    assign empty = count_reg == '0;

    assign cmd.enq = accept && (s_opcode == OP_ENQUEUE) && !full;
    assign cmd.deq = accept && (s_opcode == OP_DEQUEUE) && !empty;
    assign cmd.ent.pri = s_priority_req;
    assign cmd.ent.tag = s_task_tag;

    // neighbor wiring; ends of the chain see the request entry
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            left_ent[i] = (i == 0) ? cmd.ent : cell_ent[(i == 0) ? 0 : i - 1];
            take_left[i] = (i == 0) ? 1'b0 : take[(i == 0) ? 0 : i - 1];
            right_ent[i] = (i == CAPACITY - 1) ? cmd.ent
                                               : cell_ent[(i == CAPACITY - 1) ? i : i + 1];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_cell #(
            .CNT_W (CNT_W),
            .INDEX (g)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .count     (count_reg),
            .take_left (take_left[g]),
            .left_ent  (left_ent[g]),
            .right_ent (right_ent[g]),
            .take      (take[g]),
            .ent       (cell_ent[g])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.enq) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.deq) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_ext = {{OCC_W{1'b0}}, count_next};

    always_comb begin
        m_valid_next = m_valid_reg;
        status_next = status_reg;
        out_next = out_reg;
        occ_next = occ_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            occ_next = count_ext[OCC_W-1:0];
            out_next = '0;
            if (s_opcode == OP_ENQUEUE) begin
                status_next = full ? ST_FULL : ST_OK;
            end else if (empty) begin
                status_next = ST_EMPTY;
            end else begin
                status_next = ST_OK;
                out_next = cell_ent[0];
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        out_reg <= out_next;
        occ_reg <= occ_next;
    end

    assign m_valid = m_valid_reg;
    assign m_status = status_reg;
    assign m_out_priority = out_reg.pri;
    assign m_out_tag = out_reg.tag;
    assign m_occupancy = occ_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP)
        else $error("entry count above capacity");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted request produced no result");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_opcode == OP_DEQUEUE) && empty) |=> (status_reg == ST_EMPTY))
        else $error("dequeue on empty queue not flagged");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (cell_ent[0].pri >= cell_ent[1].pri))
        else $error("head entries out of order");

endmodule
